>>> design/kls_pkg.sv
package kls_pkg;

    // Width of one time or component value (Q16.16).
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned SEG_W   = 6;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned FRAC_W  = 17;
    localparam int unsigned KEY_W   = 4 * VAL_W;

    // Opcodes of the input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_query;  // capture query time, start search at key 0
        logic cap_lo;      // capture lower key from read data
        logic cap_hi;      // capture upper key from read data
        logic step;        // advance the search index
        logic div_start;   // begin the fraction division
        logic div_step;    // one restoring division step
        logic mul_cap;     // capture the three products
        logic fin;         // compute the output item
        logic early;       // result is the lower key as is
    } kls_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early_hit;   // query at or before key 0, or a single key in use
        logic bracket;     // lower/upper bracket the query
        logic last_seg;    // the pair just read is the last one
        logic div_done;    // all division steps taken
    } kls_sts_t;

endpackage

>>> design/kls_ram.sv
module kls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/kls_datapath.sv
module kls_datapath #(
    parameter int KEY_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kls_pkg::kls_cmd_t               cmd,
    output kls_pkg::kls_sts_t               sts,
    input  logic                            wr_en,
    input  logic [$clog2(KEY_DEPTH)-1:0]    wr_addr,
    input  logic [kls_pkg::KEY_W-1:0]       wr_data,
    input  logic [kls_pkg::VAL_W-1:0]       query_time,
    input  logic [kls_pkg::CNT_W-1:0]       key_count,
    output logic signed [kls_pkg::VAL_W-1:0] res_x,
    output logic signed [kls_pkg::VAL_W-1:0] res_y,
    output logic signed [kls_pkg::VAL_W-1:0] res_z,
    output logic [kls_pkg::SEG_W-1:0]       res_seg
);

    import kls_pkg::*;

    localparam int AW = $clog2(KEY_DEPTH);
    localparam int NW = AW + 1;
    localparam int DW = VAL_W + 16;
    localparam int PW = VAL_W + 1 + FRAC_W + 1;

    logic [KEY_W-1:0] rdata;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [NW-1:0]    n_eff;
    logic [VAL_W-1:0] q_reg;
    logic [KEY_W-1:0] lo_reg, hi_reg;
    logic [DW-1:0]    rem_reg, quo_reg;
    logic [VAL_W-1:0] den_reg;
    logic [5:0]       dcnt_reg;
    logic signed [PW-1:0] px_reg, py_reg, pz_reg;
    logic [VAL_W-1:0] t_lo, t_hi;
    logic [DW:0]      rem_sh;
    logic [FRAC_W-1:0] frac;

    kls_ram #(.WIDTH(KEY_W), .DEPTH(KEY_DEPTH)) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // Clamp the key count into 1..KEY_DEPTH.
    always_comb
    begin
        if (key_count == '0)
        begin
            n_eff = NW'(1);
        end
        else if ({{(32-CNT_W){1'b0}}, key_count} > 32'(KEY_DEPTH))
        begin
            n_eff = NW'(KEY_DEPTH);
        end
        else
        begin
            n_eff = NW'(key_count);
        end
    end

    assign t_lo = lo_reg[KEY_W-1 -: VAL_W];
    assign t_hi = hi_reg[KEY_W-1 -: VAL_W];
    assign idx_next = idx_reg + AW'(1);

    assign sts.early_hit = (n_eff == NW'(1)) || (q_reg <= rdata[KEY_W-1 -: VAL_W]);
    assign sts.bracket   = (t_lo <= q_reg) && (q_reg <= t_hi);
    assign sts.last_seg  = ({1'b0, idx_reg} + NW'(1)) >= n_eff;
    assign sts.div_done  = (dcnt_reg == 6'd0);

    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign frac   = quo_reg[FRAC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_query)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_next;
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= 6'(DW);
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_reg <= query_time;
        end
        if (cmd.cap_lo)
        begin
            lo_reg <= rdata;
        end
        if (cmd.cap_hi)
        begin
            hi_reg <= rdata;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= {q_reg - t_lo, 16'd0};
            den_reg <= t_hi - t_lo;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {{(DW+1-VAL_W){1'b0}}, den_reg})
            begin
                rem_reg <= DW'(rem_sh - {{(DW+1-VAL_W){1'b0}}, den_reg});
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.mul_cap)
        begin
            // A zero-length segment gives a zero fraction.
            px_reg <= (den_reg == '0) ? '0 :
                PW'((VAL_W+1)'($signed(hi_reg[95:64])) - (VAL_W+1)'($signed(lo_reg[95:64])))
                * $signed({1'b0, frac});
            py_reg <= (den_reg == '0) ? '0 :
                PW'((VAL_W+1)'($signed(hi_reg[63:32])) - (VAL_W+1)'($signed(lo_reg[63:32])))
                * $signed({1'b0, frac});
            pz_reg <= (den_reg == '0) ? '0 :
                PW'((VAL_W+1)'($signed(hi_reg[31:0])) - (VAL_W+1)'($signed(lo_reg[31:0])))
                * $signed({1'b0, frac});
        end
        if (cmd.fin)
        begin
            if (cmd.early)
            begin
                res_seg <= SEG_W'(idx_reg);
                res_x <= lo_reg[95:64];
                res_y <= lo_reg[63:32];
                res_z <= lo_reg[31:0];
            end
            else
            begin
                // The index points at the upper key; the segment is the one below it.
                res_seg <= SEG_W'(idx_reg - AW'(1));
                // The arithmetic shift floors toward minus infinity.
                res_x <= lo_reg[95:64] + VAL_W'(px_reg >>> 16);
                res_y <= lo_reg[63:32] + VAL_W'(py_reg >>> 16);
                res_z <= lo_reg[31:0]  + VAL_W'(pz_reg >>> 16);
            end
        end
    end

endmodule

>>> design/kls_ctrl.sv
module kls_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  kls_pkg::kls_sts_t sts,
    output kls_pkg::kls_cmd_t cmd,
    output logic              busy,
    output logic              res_valid,
    input  logic              res_stall
);

    import kls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_CAP0, S_RDHI, S_CAPHI, S_CHECK,
        S_DIV, S_MUL, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_query = 1'b1;
                    state_next     = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_CAP0;
            end
            S_CAP0:
            begin
                cmd.cap_lo = 1'b1;
                if (sts.early_hit)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_RDHI;
                end
            end
            S_RDHI:
            begin
                state_next = S_CAPHI;
            end
            S_CAPHI:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // idx points at the upper key here.
                if (sts.bracket)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (sts.last_seg)
                begin
                    cmd.cap_lo = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.cap_lo = 1'b1;
                    cmd.step   = 1'b1;
                    state_next = S_RDHI;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.mul_cap = 1'b1;
                    state_next  = S_MUL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.fin = 1'b1;
                state_next = S_OUT;
            end
            S_FIN:
            begin
                cmd.fin   = 1'b1;
                cmd.early = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_OUT);

endmodule

>>> design/keyframe_linear_sampler_core.sv
// Channel  | Valid      | Stall      | Payload
// input    | in_valid   | in_stall   | op, key_index, key_time, key_x/y/z, query_time
// output   | out_valid  | out_stall  | out_x, out_y, out_z, segment
// config   | cfg_we     | -          | cfg_data (key_count)
//
// A keyframe write is accepted whenever the block is idle.
// A query runs a linear search over the key pairs and, when a pair brackets the query
// time, a bit-serial restoring division of the fraction and a multiply of the three
// component deltas. The search and the divider account for most of its run time.
// Reset clears the controller and sets key_count to 1; the key table is not cleared.
// A stalled result holds in the output registers; no new item is accepted meanwhile.
module keyframe_linear_sampler_core #(
    parameter int KEY_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kls_pkg::CNT_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [kls_pkg::SEG_W-1:0]         key_index,
    input  logic [kls_pkg::VAL_W-1:0]         key_time,
    input  logic signed [kls_pkg::VAL_W-1:0]  key_x,
    input  logic signed [kls_pkg::VAL_W-1:0]  key_y,
    input  logic signed [kls_pkg::VAL_W-1:0]  key_z,
    input  logic [kls_pkg::VAL_W-1:0]         query_time,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [kls_pkg::VAL_W-1:0]  out_x,
    output logic signed [kls_pkg::VAL_W-1:0]  out_y,
    output logic signed [kls_pkg::VAL_W-1:0]  out_z,
    output logic [kls_pkg::SEG_W-1:0]         segment
);

    import kls_pkg::*;

    localparam int AW = $clog2(KEY_DEPTH);

    logic [CNT_W-1:0] key_count_reg;
    logic             busy;
    logic             accept;
    logic             wr_ok;
    kls_cmd_t         cmd;
    kls_sts_t         sts;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    // Slots beyond the table depth are ignored.
    assign wr_ok = ({{(32-SEG_W){1'b0}}, key_index} < 32'(KEY_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_data;
        end
    end

    kls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && (op == OP_QUERY)),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (out_valid),
        .res_stall (out_stall)
    );

    kls_datapath #(.KEY_DEPTH(KEY_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .wr_en      (accept && (op == OP_WRITE) && wr_ok),
        .wr_addr    (AW'(key_index)),
        .wr_data    ({key_time, key_x, key_y, key_z}),
        .query_time (query_time),
        .key_count  (key_count_reg),
        .res_x      (out_x),
        .res_y      (out_y),
        .res_z      (out_z),
        .res_seg    (segment)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the keyframe linear sampler. A scoreboard object keeps its own
// copy of the key table and of key_count, predicts each query result the moment the
// query item is accepted, and compares results in order as they leave the block.
// Stimulus runs as a short directed opening followed by phases: each phase programs a
// key count while the block is idle, loads a sorted key table and then mixes queries
// with keyframe rewrites.

typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  seg;
} sample_t;

class kls_scoreboard;
    logic [31:0] t_tab [64];
    logic [31:0] x_tab [64];
    logic [31:0] y_tab [64];
    logic [31:0] z_tab [64];
    bit          written [64];
    int unsigned count_reg;
    sample_t     expected_q [$];
    int unsigned fails;

    function new();
        count_reg = 1;
        fails = 0;
        foreach (written[i]) written[i] = 0;
    endfunction

    function int unsigned used_keys();
        if (count_reg == 0) return 1;
        if (count_reg > 64) return 64;
        return count_reg;
    endfunction

    // a + floor((b - a) * f / 2^16), with the floor toward minus infinity.
    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] f);
        longint av;
        longint p;
        longint r;
        av = longint'($signed(a));
        p = (longint'($signed(b)) - av) * longint'({15'b0, f});
        if (p >= 0) r = av + p / 65536;
        else        r = av - (((-p) + 65535) / 65536);
        return r[31:0];
    endfunction

    function void note_item(logic op, logic [5:0] idx, logic [31:0] kt, logic [31:0] kx,
                            logic [31:0] ky, logic [31:0] kz, logic [31:0] qt);
        int unsigned n;
        int unsigned seg;
        logic [16:0] f;
        logic [63:0] num;
        logic [31:0] len;
        sample_t s;
        if (op == kls_pkg::OP_WRITE) begin
            t_tab[idx] = kt;
            x_tab[idx] = kx;
            y_tab[idx] = ky;
            z_tab[idx] = kz;
            written[idx] = 1;
            return;
        end
        n = used_keys();
        seg = 0;
        f = '0;
        if (n > 1 && qt > t_tab[0]) begin
            seg = n - 1;
            for (int i = 0; i + 1 < n; i++) begin
                if (t_tab[i] <= qt && qt <= t_tab[i+1]) begin
                    seg = i;
                    len = t_tab[i+1] - t_tab[i];
                    if (len != 0) begin
                        num = {32'b0, qt - t_tab[i]} << 16;
                        num = num / {32'b0, len};
                        f = num[16:0];
                    end
                    break;
                end
            end
        end
        if (seg + 1 < n) begin
            s.x = blend(x_tab[seg], x_tab[seg+1], f);
            s.y = blend(y_tab[seg], y_tab[seg+1], f);
            s.z = blend(z_tab[seg], z_tab[seg+1], f);
        end else begin
            s.x = x_tab[seg];
            s.y = y_tab[seg];
            s.z = z_tab[seg];
        end
        s.seg = seg[5:0];
        expected_q.push_back(s);
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [5:0] seg);
        sample_t e;
        if (expected_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("ERROR: unexpected result x=%h y=%h z=%h seg=%0d", x, y, z, seg);
            return;
        end
        e = expected_q.pop_front();
        if (e.x !== x || e.y !== y || e.z !== z || e.seg !== seg) begin
            fails++;
            if (fails <= 10)
                $display("ERROR: expected x=%h y=%h z=%h seg=%0d, got x=%h y=%h z=%h seg=%0d",
                         e.x, e.y, e.z, e.seg, x, y, z, seg);
        end
    endfunction
endclass

module testbench;
    import kls_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CNT_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     op;
    logic [SEG_W-1:0]         key_index;
    logic [VAL_W-1:0]         key_time;
    logic signed [VAL_W-1:0]  key_x;
    logic signed [VAL_W-1:0]  key_y;
    logic signed [VAL_W-1:0]  key_z;
    logic [VAL_W-1:0]         query_time;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;
    logic [SEG_W-1:0]         segment;

    kls_scoreboard sb;

    // Sender pacing: offering mirrors in_valid so that no step lowers it twice.
    bit offering;
    int burst_left;

    // Long receiver hold-off, requested by the stimulus and counted by the receiver.
    bit hold_req;
    int hold_left;
    int stall_mode;
    int stall_window;

    keyframe_linear_sampler_core #(.KEY_DEPTH(64)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .key_index(key_index),
        .key_time(key_time), .key_x(key_x), .key_y(key_y), .key_z(key_z),
        .query_time(query_time), .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .segment(segment)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Results are taken on the edge where the block presents them unstalled.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_x, out_y, out_z, segment);
    end

    // Receiver: windows of no stall, light stall and heavy stall, plus the one long hold.
    initial
    begin
        out_stall = 0;
        hold_left = 0;
        stall_window = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = 1500;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_window == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    stall_window = $urandom_range(20, 200);
                end
                stall_window--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one item and hold it until the block takes it, then pace the next one.
    task automatic offer(logic o, logic [5:0] idx, logic [31:0] kt, logic [31:0] kx,
                         logic [31:0] ky, logic [31:0] kz, logic [31:0] qt);
        op <= o;
        key_index <= idx;
        key_time <= kt;
        key_x <= kx;
        key_y <= ky;
        key_z <= kz;
        query_time <= qt;
        in_valid <= 1'b1;
        offering = 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(o, idx, kt, kx, ky, kz, qt);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            offering = 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // Now and then a long stretch with no gaps at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
    endtask

    task automatic write_key(logic [5:0] idx, logic [31:0] kt, logic [31:0] kx,
                             logic [31:0] ky, logic [31:0] kz);
        offer(OP_WRITE, idx, kt, kx, ky, kz, $urandom());
    endtask

    task automatic query(logic [31:0] qt);
        offer(OP_QUERY, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(), qt);
    endtask

    // Let every query drain, wait out a possible trailing search, then program key_count.
    task automatic set_key_count(logic [CNT_W-1:0] value);
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 0;
        end
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (260) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.count_reg = 32'(value);
    endtask

    // Program a key count, load keys 0..n-1 in time order, then mix queries and rewrites.
    task automatic run_phase(logic [CNT_W-1:0] count, int items);
        int unsigned n;
        int unsigned seg;
        logic [31:0] t;
        logic [31:0] stride;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [5:0] slot;
        int pick;
        set_key_count(count);
        n = sb.used_keys();
        t = $urandom_range(0, 32'h0100_0000);
        stride = (32'hFFFF_FFFF - t) / n;
        for (int i = 0; i < n; i++)
        begin
            write_key(6'(i), t, $urandom(), $urandom(), $urandom());
            // Repeated times make zero-length segments now and then.
            if ($urandom_range(0, 9) != 0)
                t = t + $urandom_range(1, stride);
        end
        for (int k = 0; k < items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                slot = 6'($urandom());
                if (pick < 4)
                    write_key(slot, $urandom(), $urandom(), $urandom(), $urandom());
                else if (sb.written[slot])
                    write_key(slot, sb.t_tab[slot], $urandom(), $urandom(), $urandom());
                else
                    write_key(slot, $urandom(), $urandom(), $urandom(), $urandom());
            end
            else if (pick < 70 && n > 1)
            begin
                seg = $urandom_range(0, n - 2);
                lo = sb.t_tab[seg];
                hi = sb.t_tab[seg + 1];
                if (hi >= lo) query(lo + $urandom_range(0, hi - lo));
                else          query($urandom());
            end
            else if (pick < 80)
                query(($urandom_range(0, 1) == 0) ? 32'h0 : sb.t_tab[0]);
            else if (pick < 90)
                query(($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : sb.t_tab[n - 1]);
            else
                query($urandom());
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_data = '0;
        in_valid = 0;
        op = OP_WRITE;
        key_index = '0;
        key_time = '0;
        key_x = '0;
        key_y = '0;
        key_z = '0;
        query_time = '0;
        offering = 0;
        burst_left = 4;
        hold_req = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. With the reset count of one every query returns key 0.
        write_key(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        query(32'h0);
        query(32'h8000_0000);
        query(32'hFFFF_FFFF);
        // Two keys whose x and y span the full component range in opposite directions.
        set_key_count(2);
        write_key(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        query(32'h0);
        query(32'h8000_0000);
        query(32'h8000_0001);
        query(32'hC000_0000);
        query(32'hFFFF_FFFF);
        // Shorten the last key so that a late time falls past it.
        write_key(1, 32'h9000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        query(32'hFFFF_FFFF);
        query(32'h8800_0000);
        // A count of zero behaves as a single key.
        set_key_count(0);
        query(32'hFFFF_FFFF);

        // Random phases, the long receiver hold-off lands in the full-table phase.
        run_phase(64, 60);
        hold_req = 1;
        run_phase(64, 120);
        run_phase(127, 100);
        run_phase(2, 100);
        run_phase(1, 60);
        run_phase(3, 80);
        for (int p = 0; p < 4; p++)
            run_phase(7'($urandom_range(4, 63)), 40);
        run_phase(64, 60);

        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 0;
        end
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.fails == 0)
            $display("keyframe_linear_sampler_core verification clean");
        else
            $display("keyframe_linear_sampler_core verification failed");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("keyframe_linear_sampler_core verification failed");
        $finish;
    end

endmodule
